FILE: hw/rtl/table_random_swap_shuffler_unit_assert.svh
// Assertion helpers shared by the shuffler RTL.
// Each macro wraps one concurrent assertion, clocked on the rising edge and
// switched off while the asynchronous reset is held.
`ifndef TABLE_RANDOM_SWAP_SHUFFLER_UNIT_ASSERT_SVH
`define TABLE_RANDOM_SWAP_SHUFFLER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRSS_ASSERT_SAME(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRSS_ASSERT_NEXT(lbl, clk_i, rst_ni, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/trss_pkg.sv
`default_nettype none

package trss_pkg;

	localparam int unsigned LEN_W  = 11;
	localparam int unsigned IDX_W  = 10;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned RAND_W = 31;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned ST_W   = 3;
	localparam int unsigned OP_W   = 3;

	// Item kinds.
	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FILL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SWAP = 2'd2;
	localparam logic [KIND_W-1:0] KIND_READ = 2'd3;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_OK    = 3'd0;
	localparam logic [ST_W-1:0] ST_SIZE  = 3'd1;
	localparam logic [ST_W-1:0] ST_INDEX = 3'd2;
	localparam logic [ST_W-1:0] ST_ZERO  = 3'd3;
	localparam logic [ST_W-1:0] ST_DONE  = 3'd4;

	// Table port operations issued by the controller.
	localparam logic [OP_W-1:0] MEM_NONE    = 3'd0;
	localparam logic [OP_W-1:0] MEM_RD_POS  = 3'd1;
	localparam logic [OP_W-1:0] MEM_RD_J    = 3'd2;
	localparam logic [OP_W-1:0] MEM_RD_IDX  = 3'd3;
	localparam logic [OP_W-1:0] MEM_WR_POS  = 3'd4;
	localparam logic [OP_W-1:0] MEM_WR_J    = 3'd5;
	localparam logic [OP_W-1:0] MEM_WR_IDX  = 3'd6;
	localparam logic [OP_W-1:0] MEM_WR_FILL = 3'd7;

	typedef struct packed {
		logic            capture;
		logic            pos_clear;
		logic            pos_inc;
		logic            div_step;
		logic            fill_step;
		logic [OP_W-1:0] mem_op;
		logic            capture_a;
		logic            capture_rd;
		logic            result_load;
	} cmd_t;

	typedef struct packed {
		logic              in_err;
		logic [KIND_W-1:0] in_kind;
		logic              div_last;
		logic              fill_last;
	} sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/trss_if.sv
`default_nettype none

interface trss_item_if;
	logic                           valid;
	logic                           ready;
	logic [trss_pkg::KIND_W-1:0]    kind;
	logic [trss_pkg::IDX_W-1:0]     index;
	logic signed [trss_pkg::VAL_W-1:0] value;
	logic [trss_pkg::RAND_W-1:0]    rand_word;

	modport source (output valid, output kind, output index, output value,
		output rand_word, input ready);
	modport sink (input valid, input kind, input index, input value,
		input rand_word, output ready);
endinterface

interface trss_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [trss_pkg::VAL_W-1:0] read_value;
	logic [trss_pkg::ST_W-1:0]         status;
	logic                              pass_done;

	modport source (output valid, output read_value, output status, output pass_done,
		input ready);
	modport sink (input valid, input read_value, input status, input pass_done,
		output ready);
endinterface

interface trss_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [trss_pkg::LEN_W-1:0] length;

	modport source (output valid, output length, input ready);
	modport sink (input valid, input length, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/trss_ctrl.sv
`default_nettype none

module trss_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire trss_pkg::sts_t sts,
	output trss_pkg::cmd_t      cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_LDWR   = 4'd1;
	localparam logic [3:0] S_FILL   = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_RDA    = 4'd4;
	localparam logic [3:0] S_RDB    = 4'd5;
	localparam logic [3:0] S_WRA    = 4'd6;
	localparam logic [3:0] S_WRB    = 4'd7;
	localparam logic [3:0] S_RDX    = 4'd8;
	localparam logic [3:0] S_CAPX   = 4'd9;
	localparam logic [3:0] S_RESULT = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mem_op = trss_pkg::MEM_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (sts.in_err) begin
						state_d = S_RESULT;
					end else begin
						case (sts.in_kind)
							trss_pkg::KIND_LOAD: state_d = S_LDWR;
							trss_pkg::KIND_FILL: begin
								cmd.pos_clear = 1'b1;
								state_d = S_FILL;
							end
							trss_pkg::KIND_SWAP: state_d = S_DIV;
							default: state_d = S_RDX;
						endcase
					end
				end
			end
			S_LDWR: begin
				cmd.mem_op = trss_pkg::MEM_WR_IDX;
				state_d = S_RESULT;
			end
			S_FILL: begin
				cmd.mem_op = trss_pkg::MEM_WR_FILL;
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = S_RESULT;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = S_RDA;
				end
			end
			S_RDA: begin
				cmd.mem_op = trss_pkg::MEM_RD_POS;
				state_d = S_RDB;
			end
			S_RDB: begin
				cmd.mem_op = trss_pkg::MEM_RD_J;
				cmd.capture_a = 1'b1;
				state_d = S_WRA;
			end
			S_WRA: begin
				cmd.mem_op = trss_pkg::MEM_WR_POS;
				state_d = S_WRB;
			end
			S_WRB: begin
				cmd.mem_op = trss_pkg::MEM_WR_J;
				cmd.pos_inc = 1'b1;
				state_d = S_RESULT;
			end
			S_RDX: begin
				cmd.mem_op = trss_pkg::MEM_RD_IDX;
				state_d = S_CAPX;
			end
			S_CAPX: begin
				cmd.capture_rd = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (out_free) begin
					cmd.result_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/trss_datapath.sv
`default_nettype none

module trss_datapath #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [trss_pkg::LEN_W-1:0]         cfg_length,
	input  wire logic [trss_pkg::KIND_W-1:0]        kind,
	input  wire logic [trss_pkg::IDX_W-1:0]         index,
	input  wire logic signed [trss_pkg::VAL_W-1:0]  value,
	input  wire logic [trss_pkg::RAND_W-1:0]        rand_word,
	input  wire trss_pkg::cmd_t                     cmd,
	output trss_pkg::sts_t                          sts,
	output logic signed [trss_pkg::VAL_W-1:0]       read_value,
	output logic [trss_pkg::ST_W-1:0]               status,
	output logic                                    pass_done
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned CW = $clog2(trss_pkg::RAND_W);
	localparam int unsigned LW = trss_pkg::LEN_W;
	localparam int unsigned VW = trss_pkg::VAL_W;

	logic [LW-1:0]                  length_q;
	logic [PW-1:0]                  pos_q;
	logic [AW-1:0]                  idx_q;
	logic [VW-1:0]                  value_q;
	logic [trss_pkg::RAND_W-1:0]    rand_q;
	logic [LW-1:0]                  rem_q;
	logic [CW-1:0]                  div_cnt_q;
	logic [AW-1:0]                  fill_k_q;
	logic [VW-1:0]                  rdata_q;
	logic [VW-1:0]                  a_q;
	logic [VW-1:0]                  rd_q;
	logic [trss_pkg::ST_W-1:0]      item_st_q;
	logic [VW-1:0]                  out_value_q;
	logic [trss_pkg::ST_W-1:0]      out_status_q;
	logic                           out_done_q;
	logic [VW-1:0]                  mem_q [TABLE_DEPTH];

	logic [trss_pkg::ST_W-1:0]      in_status;
	logic [LW:0]                    trial;
	logic [LW:0]                    len_ext;
	logic [AW-1:0]                  pos_addr;
	logic [AW-1:0]                  j_addr;
	logic                           mem_we;
	logic                           mem_re;
	logic [AW-1:0]                  wr_addr;
	logic [AW-1:0]                  rd_addr;
	logic [VW-1:0]                  wr_data;

	// Error checks in priority order, evaluated on the incoming beat.
	always_comb begin
		in_status = trss_pkg::ST_OK;
		if (length_q > LW'(TABLE_DEPTH)) begin
			in_status = trss_pkg::ST_SIZE;
		end else if (length_q == '0) begin
			in_status = trss_pkg::ST_ZERO;
		end else if ((kind inside {trss_pkg::KIND_LOAD, trss_pkg::KIND_READ}) &&
				(LW'(index) >= length_q)) begin
			in_status = trss_pkg::ST_INDEX;
		end else if ((kind == trss_pkg::KIND_SWAP) && (LW'(pos_q) >= length_q)) begin
			in_status = trss_pkg::ST_DONE;
		end
	end

	assign sts.in_err    = (in_status != trss_pkg::ST_OK);
	assign sts.in_kind   = kind;
	assign sts.div_last  = (div_cnt_q == CW'(trss_pkg::RAND_W - 1));
	assign sts.fill_last = ((LW'(fill_k_q) + LW'(1)) == length_q);

	// One restoring step of the remainder per cycle, most significant bit first.
	assign len_ext = {1'b0, length_q};
	assign trial   = {rem_q, rand_q[trss_pkg::RAND_W-1]};

	assign pos_addr = pos_q[AW-1:0];
	assign j_addr   = rem_q[AW-1:0];

	always_comb begin
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		wr_addr = pos_addr;
		rd_addr = pos_addr;
		wr_data = rdata_q;
		case (cmd.mem_op)
			trss_pkg::MEM_RD_POS: begin
				mem_re  = 1'b1;
				rd_addr = pos_addr;
			end
			trss_pkg::MEM_RD_J: begin
				mem_re  = 1'b1;
				rd_addr = j_addr;
			end
			trss_pkg::MEM_RD_IDX: begin
				mem_re  = 1'b1;
				rd_addr = idx_q;
			end
			trss_pkg::MEM_WR_POS: begin
				mem_we  = 1'b1;
				wr_addr = pos_addr;
				wr_data = rdata_q;
			end
			trss_pkg::MEM_WR_J: begin
				mem_we  = 1'b1;
				wr_addr = j_addr;
				wr_data = a_q;
			end
			trss_pkg::MEM_WR_IDX: begin
				mem_we  = 1'b1;
				wr_addr = idx_q;
				wr_data = value_q;
			end
			trss_pkg::MEM_WR_FILL: begin
				mem_we  = 1'b1;
				wr_addr = fill_k_q;
				wr_data = VW'(fill_k_q);
			end
			default: begin
				mem_we = 1'b0;
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			pos_q    <= '0;
		end else begin
			if (cfg_we) begin
				length_q <= cfg_length;
			end
			if (cmd.pos_clear) begin
				pos_q <= '0;
			end else if (cmd.pos_inc) begin
				pos_q <= pos_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q     <= index[AW-1:0];
			value_q   <= value;
			rand_q    <= rand_word;
			rem_q     <= '0;
			div_cnt_q <= '0;
			fill_k_q  <= '0;
			rd_q      <= '0;
			item_st_q <= in_status;
		end else begin
			if (cmd.div_step) begin
				if (trial >= len_ext) begin
					rem_q <= LW'(trial - len_ext);
				end else begin
					rem_q <= LW'(trial);
				end
				rand_q    <= rand_q << 1;
				div_cnt_q <= div_cnt_q + CW'(1);
			end
			if (cmd.fill_step) begin
				fill_k_q <= fill_k_q + AW'(1);
			end
			if (cmd.capture_rd) begin
				rd_q <= rdata_q;
			end
		end
		if (cmd.capture_a) begin
			a_q <= rdata_q;
		end
		if (cmd.result_load) begin
			out_value_q  <= rd_q;
			out_status_q <= item_st_q;
			out_done_q   <= (LW'(pos_q) >= length_q);
		end
	end

	assign read_value = out_value_q;
	assign status     = out_status_q;
	assign pass_done  = out_done_q;

endmodule

`default_nettype wire

FILE: hw/rtl/table_random_swap_shuffler_unit.sv
// Table shuffler with a naive random swap pass. The unit holds TABLE_DEPTH
// signed 32-bit entries in a single-port-write, single-port-read memory and
// a pass position. Each item beat on the item channel is one of four kinds:
// load writes one entry, fill writes entries 0 to length-1 with their own
// index and restarts the pass, swap exchanges the entry at the pass position
// with the entry at rand_word modulo length and advances the position, and
// read returns one entry. Every item yields exactly one result beat with a
// status code and the pass_done flag. The length register is written over
// the cfg channel; the user must write it only while the unit is idle, as the
// unit itself does not enforce this. The table contents after reset are
// undefined until loaded or filled. Items are processed one at a time. A
// swap runs the bit-serial remainder unit (one dividend bit per cycle), then
// the two reads and two writes that the one memory read port and one write
// port need, and then loads the result register. The next item can be
// accepted in the cycle after the result register is loaded. A finished
// result waits in its output register while the next item may already be
// accepted; the result state only stalls if that register is still full.
`default_nettype none

`include "table_random_swap_shuffler_unit_assert.svh"

module table_random_swap_shuffler_unit #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input wire logic       clk,
	input wire logic       arst_n,
	trss_item_if.sink      item,
	trss_result_if.source  result,
	trss_cfg_if.sink       cfg
);

	trss_pkg::cmd_t cmd;
	trss_pkg::sts_t sts;
	logic           in_ready;
	logic           out_valid;

	// The length register takes every write beat immediately.
	assign cfg.ready = 1'b1;

	// Ready is high only while the controller waits for a new item.
	assign item.ready   = in_ready;
	assign result.valid = out_valid;

	// The controller sequences each item: it picks the memory operation of
	// every cycle, steps the remainder unit and the fill counter, and hands
	// the finished result to the output register.
	trss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the table, the pass position, the length register,
	// the remainder unit and the result register.
	trss_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg.valid),
		.cfg_length (cfg.length),
		.kind       (item.kind),
		.index      (item.index),
		.value      (item.value),
		.rand_word  (item.rand_word),
		.cmd        (cmd),
		.sts        (sts),
		.read_value (result.read_value),
		.status     (result.status),
		.pass_done  (result.pass_done)
	);

	// Only one item is in flight, so an accepted beat always drops ready.
	`TRSS_ASSERT_NEXT(a_one_in_flight, clk, arst_n, item.valid && item.ready, !item.ready, "item accepted while another item is in flight")

	// A failed item never returns table data.
	`TRSS_ASSERT_SAME(a_err_zero_value, clk, arst_n, result.valid && (result.status != trss_pkg::ST_OK), result.read_value == '0, "error result carries a nonzero read value")

	// With a zero length the pass position is always at or past the end.
	`TRSS_ASSERT_SAME(a_zero_len_done, clk, arst_n, result.valid && (result.status == trss_pkg::ST_ZERO), result.pass_done, "zero-length result without pass_done")

endmodule

`default_nettype wire

FILE: tb/tb_table_random_swap_shuffler_unit.sv
`default_nettype none

module tb_table_random_swap_shuffler_unit;

	// The table depth that the unit is built with here. The model of the table
	// below uses the same depth.
	localparam int unsigned DEPTH = 256;
	localparam int unsigned DEPTH_AW = $clog2(DEPTH);
	// Random items after the directed tests. This only tells the stimulus
	// when to stop.
	localparam int unsigned RANDOM_ITEMS = 1025;
	// The worst case per item is a fill of the full table behind the longest
	// sender gap and a slow receiver.
	localparam int unsigned CYCLE_LIMIT = 1000000;
	// Nothing is in flight once every result has come back, so this leaves time
	// for one more beat that should not be there to show up.
	localparam int unsigned TAIL_CYCLES = 50;

	typedef struct {
		logic signed [trss_pkg::VAL_W-1:0] read_value;
		logic [trss_pkg::ST_W-1:0]         status;
		logic                              pass_done;
	} shuffle_result_t;

	// Receiver behavior: always ready, ready about half the time, or ready
	// with a chance of about one in six.
	typedef enum logic [1:0] {
		RX_STEADY,
		RX_CHOPPY,
		RX_SLOW
	} rx_mode_e;

	logic clk = 1'b0;
	logic arst_n;

	trss_item_if   item_bus();
	trss_result_if result_bus();
	trss_cfg_if    length_bus();

	table_random_swap_shuffler_unit #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_bus),
		.result(result_bus),
		.cfg(length_bus)
	);

	// Our own copy of the unit's state. The loaded flags track which entries
	// have been written by a load or a fill, because the contents of the
	// table are undefined before that and must never be read.
	logic signed [trss_pkg::VAL_W-1:0] shadow_table [DEPTH];
	bit                                shadow_loaded [DEPTH];
	logic [8:0]                        shadow_pos;
	logic [trss_pkg::LEN_W-1:0]        shadow_len;

	// Results that accepted items still owe us, oldest first.
	shuffle_result_t pending_results[$];
	shuffle_result_t oldest_result;

	int unsigned mismatch_count;
	int unsigned items_sent;
	int unsigned cycle_count;
	int unsigned burst_left;
	rx_mode_e    rx_mode;
	int unsigned rx_run;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog. A hang anywhere ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// The receiver picks a mode, keeps it for a random number of cycles, and
	// then picks again. Long steady stretches alternate with heavy stalling,
	// so result beats get held back at every point of the unit's work.
	always @(negedge clk) begin
		if (rx_run == 0) begin
			rx_mode = rx_mode_e'($urandom_range(0, 2));
			rx_run = $urandom_range(10, 90);
		end else begin
			rx_run--;
		end
		case (rx_mode)
			RX_STEADY: result_bus.ready <= 1'b1;
			RX_CHOPPY: result_bus.ready <= ($urandom_range(0, 1) == 1);
			default:   result_bus.ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Every result beat is checked against the oldest outstanding result,
	// field by field. The values are sampled at the rising edge, before the
	// unit updates anything at that edge.
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual value %0d status %0d done %0b",
					$time, result_bus.read_value, result_bus.status, result_bus.pass_done);
				mismatch_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				if (result_bus.read_value !== oldest_result.read_value) begin
					$display("%0t: read_value mismatch: expected %0d, actual %0d",
						$time, oldest_result.read_value, result_bus.read_value);
					mismatch_count++;
				end
				if (result_bus.status !== oldest_result.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, oldest_result.status, result_bus.status);
					mismatch_count++;
				end
				if (result_bus.pass_done !== oldest_result.pass_done) begin
					$display("%0t: pass_done mismatch: expected %0b, actual %0b",
						$time, oldest_result.pass_done, result_bus.pass_done);
					mismatch_count++;
				end
			end
		end
	end

	// Applies one item to our copy of the state and returns the result that
	// the unit must produce. The length is checked before anything else:
	// a length past the table depth wins over a zero length, and both win
	// over the checks of each kind. Any error leaves the table and the pass
	// position as they were.
	function automatic shuffle_result_t predict_item(
			input logic [trss_pkg::KIND_W-1:0] kind,
			input logic [trss_pkg::IDX_W-1:0] idx,
			input logic signed [trss_pkg::VAL_W-1:0] val,
			input logic [trss_pkg::RAND_W-1:0] rnd);
		shuffle_result_t res;
		logic [trss_pkg::RAND_W-1:0] partner;
		logic signed [trss_pkg::VAL_W-1:0] held;
		int k;
		res.read_value = '0;
		res.status = trss_pkg::ST_OK;
		if (shadow_len > DEPTH) begin
			res.status = trss_pkg::ST_SIZE;
		end else if (shadow_len == 0) begin
			res.status = trss_pkg::ST_ZERO;
		end else begin
			case (kind)
				trss_pkg::KIND_LOAD: begin
					if (idx >= shadow_len) begin
						res.status = trss_pkg::ST_INDEX;
					end else begin
						shadow_table[DEPTH_AW'(idx)] = val;
						shadow_loaded[DEPTH_AW'(idx)] = 1'b1;
					end
				end
				trss_pkg::KIND_FILL: begin
					for (k = 0; k < shadow_len; k++) begin
						shadow_table[DEPTH_AW'(k)] = k;
						shadow_loaded[DEPTH_AW'(k)] = 1'b1;
					end
					shadow_pos = '0;
				end
				trss_pkg::KIND_SWAP: begin
					if (shadow_pos >= shadow_len) begin
						res.status = trss_pkg::ST_DONE;
					end else begin
						// The partner comes from the whole range, not from
						// the part not yet visited, so the shuffle is biased.
						partner = rnd % shadow_len;
						held = shadow_table[DEPTH_AW'(shadow_pos)];
						shadow_table[DEPTH_AW'(shadow_pos)] =
							shadow_table[DEPTH_AW'(partner)];
						shadow_table[DEPTH_AW'(partner)] = held;
						shadow_pos = shadow_pos + 1'b1;
					end
				end
				default: begin
					if (idx >= shadow_len) begin
						res.status = trss_pkg::ST_INDEX;
					end else begin
						res.read_value = shadow_table[DEPTH_AW'(idx)];
					end
				end
			endcase
		end
		// A length written at or below the position counts as a finished pass,
		// and so does a zero length.
		res.pass_done = (shadow_pos >= shadow_len);
		return res;
	endfunction

	// True when the item would read a table entry that was never written.
	function automatic bit touches_unloaded(input logic [trss_pkg::KIND_W-1:0] kind,
			input logic [trss_pkg::IDX_W-1:0] idx,
			input logic [trss_pkg::RAND_W-1:0] rnd);
		if (shadow_len > DEPTH || shadow_len == 0) begin
			return 1'b0;
		end
		if (kind == trss_pkg::KIND_READ) begin
			return idx < shadow_len && !shadow_loaded[DEPTH_AW'(idx)];
		end
		if (kind == trss_pkg::KIND_SWAP) begin
			return shadow_pos < shadow_len
				&& (!shadow_loaded[DEPTH_AW'(shadow_pos)]
				|| !shadow_loaded[DEPTH_AW'(rnd % shadow_len)]);
		end
		return 1'b0;
	endfunction

	function automatic logic [trss_pkg::RAND_W-1:0] draw_rand();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return trss_pkg::RAND_W'($urandom);
		endcase
	endfunction

	// Mostly an index in range. Now and then, and always when the length
	// makes every item fail anyway, any 10-bit index.
	function automatic logic [trss_pkg::IDX_W-1:0] draw_index(
			input logic [trss_pkg::LEN_W-1:0] len);
		if (len == 0 || len > DEPTH || $urandom_range(0, 7) == 0) begin
			return trss_pkg::IDX_W'($urandom);
		end
		return trss_pkg::IDX_W'($urandom_range(0, len - 1));
	endfunction

	// Sends one item beat and records its expected result once the beat is
	// accepted. The sender works in bursts: valid stays high from one item to
	// the next until the burst runs out, then drops for a random gap.
	// An item that would read an entry that was never written is turned into
	// a load of that entry, so the random stream never leaves the contract.
	task automatic send_item(input logic [trss_pkg::KIND_W-1:0] kind,
			input logic [trss_pkg::IDX_W-1:0] idx,
			input logic signed [trss_pkg::VAL_W-1:0] val,
			input logic [trss_pkg::RAND_W-1:0] rnd);
		logic [trss_pkg::KIND_W-1:0] kind_sent;
		logic [trss_pkg::IDX_W-1:0] idx_sent;
		int unsigned gap;
		kind_sent = kind;
		idx_sent = idx;
		if (touches_unloaded(kind, idx, rnd)) begin
			kind_sent = trss_pkg::KIND_LOAD;
			if (kind == trss_pkg::KIND_SWAP) begin
				idx_sent = shadow_loaded[DEPTH_AW'(shadow_pos)]
					? trss_pkg::IDX_W'(rnd % shadow_len)
					: trss_pkg::IDX_W'(shadow_pos);
			end
		end
		@(negedge clk);
		item_bus.valid <= 1'b1;
		item_bus.kind <= kind_sent;
		item_bus.index <= idx_sent;
		item_bus.value <= val;
		item_bus.rand_word <= rnd;
		do begin
			@(posedge clk);
		end while (!item_bus.ready);
		pending_results.push_back(predict_item(kind_sent, idx_sent, val, rnd));
		items_sent++;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 40)
				: $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
			@(negedge clk);
			item_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end else begin
			burst_left--;
		end
	endtask

	// Drops valid if a burst left it high. Whatever called send_item last
	// returned no later than a rising edge, so this is the next falling edge.
	task automatic stop_items();
		@(negedge clk);
		item_bus.valid <= 1'b0;
	endtask

	// The sender holds off until every outstanding result has come back.
	// Each item gives exactly one result, so the unit is idle afterwards.
	task automatic settle();
		stop_items();
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// The length register is only written while the unit is idle.
	task automatic write_length(input logic [trss_pkg::LEN_W-1:0] len);
		settle();
		@(negedge clk);
		length_bus.valid <= 1'b1;
		length_bus.length <= len;
		do begin
			@(posedge clk);
		end while (!length_bus.ready);
		shadow_len = len;
		@(negedge clk);
		length_bus.valid <= 1'b0;
	endtask

	// Straight out of reset the length is zero, so every kind reports a zero
	// length and the pass reads as done. Writing zero explicitly changes
	// nothing.
	task automatic test_reset_state();
		send_item(trss_pkg::KIND_READ, '0, '0, '0);
		send_item(trss_pkg::KIND_SWAP, '0, '0, '0);
		write_length('0);
		send_item(trss_pkg::KIND_LOAD, '1, 32'sh7FFF_FFFF, '1);
	endtask

	// Any length past the table depth makes every kind fail with the size
	// error, up to the largest value that the register holds.
	task automatic test_oversize_length();
		write_length('1);
		send_item(trss_pkg::KIND_FILL, '0, '0, '0);
		send_item(trss_pkg::KIND_READ, '0, '0, '0);
		write_length(trss_pkg::LEN_W'(1024));
		send_item(trss_pkg::KIND_LOAD, '0, 32'sh1234_5678, '0);
		write_length(trss_pkg::LEN_W'(DEPTH + 1));
		send_item(trss_pkg::KIND_SWAP, '0, '0, '1);
	endtask

	// Full table: the most negative and most positive values at both ends,
	// and a load at the largest index and a read just past the end.
	task automatic test_load_read_extremes();
		write_length(trss_pkg::LEN_W'(DEPTH));
		send_item(trss_pkg::KIND_LOAD, '0, 32'sh8000_0000, '0);
		send_item(trss_pkg::KIND_LOAD, trss_pkg::IDX_W'(DEPTH - 1), 32'sh7FFF_FFFF, '0);
		send_item(trss_pkg::KIND_READ, '0, '0, '0);
		send_item(trss_pkg::KIND_READ, trss_pkg::IDX_W'(DEPTH - 1), '0, '0);
		send_item(trss_pkg::KIND_LOAD, '1, 32'shFFFF_FFFF, '0);
		send_item(trss_pkg::KIND_READ, trss_pkg::IDX_W'(DEPTH), '0, '0);
	endtask

	// Complete passes over one and four entries, with the largest and the
	// smallest random word, and a step after each pass has finished.
	task automatic test_swap_pass();
		write_length(trss_pkg::LEN_W'(1));
		send_item(trss_pkg::KIND_FILL, '0, '0, '0);
		send_item(trss_pkg::KIND_SWAP, '0, '0, '1);
		send_item(trss_pkg::KIND_SWAP, '0, '0, '0);
		write_length(trss_pkg::LEN_W'(4));
		send_item(trss_pkg::KIND_FILL, '0, '0, '0);
		send_item(trss_pkg::KIND_SWAP, '0, '0, '1);
		send_item(trss_pkg::KIND_SWAP, '0, '0, '0);
		send_item(trss_pkg::KIND_SWAP, '0, '0, trss_pkg::RAND_W'(5));
		send_item(trss_pkg::KIND_SWAP, '0, '0, trss_pkg::RAND_W'(2));
		send_item(trss_pkg::KIND_SWAP, '0, '0, trss_pkg::RAND_W'(7));
		send_item(trss_pkg::KIND_READ, trss_pkg::IDX_W'(3), '0, '0);
	endtask

	// Shrinking the length below the pass position leaves the position where
	// it is, so the pass reads as done until the next fill restarts it.
	task automatic test_length_shrink();
		write_length(trss_pkg::LEN_W'(2));
		send_item(trss_pkg::KIND_READ, trss_pkg::IDX_W'(1), '0, '0);
		send_item(trss_pkg::KIND_SWAP, '0, '0, trss_pkg::RAND_W'(1));
		send_item(trss_pkg::KIND_FILL, '0, '0, '0);
	endtask

	// Random phases. Each one writes a length, then runs a few rounds of a
	// fill, about one full pass of swaps with reads and loads mixed in, a few
	// steps past the end, and reads of the shuffled table. Most lengths are
	// small so that passes finish often. Some rounds skip the fill, so the
	// pass position carries over from a different length. Now and then the
	// sender waits for every result before it goes on. The rounds stop soon
	// after the item count is reached, even in the middle of a long pass.
	task automatic test_random_shuffles();
		int unsigned stop_at;
		int unsigned pick;
		int unsigned steps;
		logic [trss_pkg::LEN_W-1:0] len;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				len = '0;
			end else if (pick < 8) begin
				len = trss_pkg::LEN_W'($urandom_range(DEPTH + 1, 2047));
			end else if (pick < 11) begin
				len = trss_pkg::LEN_W'(DEPTH);
			end else if (pick < 15) begin
				len = trss_pkg::LEN_W'($urandom_range(17, DEPTH - 1));
			end else begin
				len = trss_pkg::LEN_W'($urandom_range(1, 16));
			end
			write_length(len);
			repeat ($urandom_range(1, 3)) begin
				if (items_sent >= stop_at) begin
					break;
				end
				if ($urandom_range(0, 3) != 0) begin
					send_item(trss_pkg::KIND_FILL, trss_pkg::IDX_W'($urandom), $urandom,
						draw_rand());
				end
				steps = (len == 0 || len > DEPTH) ? $urandom_range(2, 6)
					: len + $urandom_range(0, 2);
				repeat (steps) begin
					if (items_sent >= stop_at) begin
						break;
					end
					pick = $urandom_range(0, 99);
					if (pick < 75) begin
						send_item(trss_pkg::KIND_SWAP, trss_pkg::IDX_W'($urandom), $urandom,
							draw_rand());
					end else if (pick < 87) begin
						send_item(trss_pkg::KIND_READ, draw_index(len), $urandom, draw_rand());
					end else if (pick < 94) begin
						send_item(trss_pkg::KIND_LOAD, draw_index(len), $urandom, draw_rand());
					end else begin
						// Noise: any kind with any field values.
						send_item(trss_pkg::KIND_W'($urandom_range(0, 3)),
							trss_pkg::IDX_W'($urandom), $urandom, draw_rand());
					end
				end
				repeat ($urandom_range(1, 4)) begin
					send_item(trss_pkg::KIND_READ, draw_index(len), $urandom, draw_rand());
				end
				if ($urandom_range(0, 5) == 0) begin
					settle();
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_bus.valid = 1'b0;
		item_bus.kind = trss_pkg::KIND_LOAD;
		item_bus.index = '0;
		item_bus.value = '0;
		item_bus.rand_word = '0;
		result_bus.ready = 1'b0;
		length_bus.valid = 1'b0;
		length_bus.length = '0;
		shadow_pos = '0;
		shadow_len = '0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_oversize_length();
		test_load_read_extremes();
		test_swap_pass();
		test_length_shrink();
		test_random_shuffles();

		// Wait for the last results, then give the unit time to show any
		// beat that it should not send.
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

`default_nettype wire
